[hdl/rws_pkg.sv]
// rws_pkg: shared types and constants for the roulette wheel selector.
// No dependencies; imported by the top level and the divider.
package rws_pkg;

	// Fixed field widths of the stream words
	localparam int OP_W    = 2;
	localparam int IDX_W   = 8;
	localparam int VAL_W   = 32;
	localparam int FRAC_W  = 16;
	localparam int CNT_W   = 9;
	localparam int SUM_W   = 40;
	localparam int OUT_W   = 32;
	localparam int IN_DW   = IDX_W + VAL_W + FRAC_W;
	localparam int OUT_DW  = IDX_W + OUT_W + OUT_W + SUM_W + OUT_W;

	// Threshold product: fraction times running total, rounded up by one LSB less than 2^16
	localparam int PROD_W  = FRAC_W + SUM_W;
	localparam logic [PROD_W-1:0] ROUND_UP = PROD_W'(16'hFFFF);

	// Operation codes carried in tuser
	typedef enum logic [OP_W-1:0] {
		OP_WRITE  = 2'd0,
		OP_SELECT = 2'd1,
		OP_STATS  = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	// Divider status seen by the controller
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

[hdl/rws_ram.sv]
// rws_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module rws_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read (read-before-write on same address)
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hdl/rws_div.sv]
// rws_div: restoring unsigned divider, one quotient bit per cycle.
// Depends on rws_pkg for the status struct.
module rws_div import rws_pkg::*; #(
	parameter int DW = 40,
	parameter int VW = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic [DW-1:0] quotient,
	output div_stat_t     stat
);

	localparam int CNTW = $clog2(DW + 1);

	logic [VW-1:0]   rem_q;
	logic [DW-1:0]   quo_q;
	logic [VW-1:0]   dvs_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [VW:0]     shifted;
	logic [VW:0]     diff;
	logic            ge;

	// one trial subtraction per cycle
	always_comb begin
		shifted = {rem_q, quo_q[DW-1]};
		diff    = shifted - {1'b0, dvs_q};
		ge      = shifted >= {1'b0, dvs_q};
	end

	// control: iteration count and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CNTW'(DW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: partial remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[VW-1:0] : shifted[VW-1:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

[hdl/roulette_wheel_selector_unit.sv]
// roulette_wheel_selector_unit: fitness-proportionate selection over a strength table.
// Depends on rws_pkg, rws_ram (strength table) and rws_div (average divider).
//
// channel | dir | handshake         | contents
// s_*     | in  | s_tvalid/s_tready | tuser opcode; tdata index, strength, fraction
// m_*     | out | m_tvalid/m_tready | tdata index, max, min, total, average
// cfg_*   | in  | cfg_wen           | entry_count (9 bits)
//
// A select walks the entries in use and stops early on a hit; statistics walk them all,
// then divide, with DW = STRENGTH_BITS + log2(MAX_ENTRIES) as the divider width.
// The walk is set by the table RAM, one entry read per cycle; the average by the
// one-bit-per-cycle divider. One word is worked on at a time.
// Reset clears the running total and sets entry_count to 1; after reset a clearing pass
// zeroes the table, one entry per cycle (all MAX_ENTRIES entries, 256 by default), with
// s_tready low. A stalled result waits in the output register while the next word is
// already taken in.
module roulette_wheel_selector_unit import rws_pkg::*; #(
	parameter int MAX_ENTRIES   = 256,
	parameter int STRENGTH_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	// [7:0] entry_index, [39:8] strength_value, [55:40] random_fraction
	input  logic [IN_DW-1:0]  s_tdata,
	// [1:0] opcode
	input  logic [OP_W-1:0]   s_tuser,
	output logic              m_tvalid,
	input  logic              m_tready,
	// [7:0] selected_index, [39:8] max_strength, [71:40] min_strength,
	// [111:72] total_strength, [143:112] avg_strength
	output logic [OUT_DW-1:0] m_tdata,
	input  logic              cfg_wen,
	input  logic [CNT_W-1:0]  cfg_wdata
);

	localparam int SB   = STRENGTH_BITS;
	localparam int AW   = $clog2(MAX_ENTRIES);
	localparam int CW   = $clog2(MAX_ENTRIES + 1);
	localparam int PW   = SB + AW;
	localparam int CMPW = PW + SUM_W;

	typedef enum logic [7:0] {
		ST_CLR     = 8'b00000001,
		ST_IDLE    = 8'b00000010,
		ST_WR_RD   = 8'b00000100,
		ST_WR_UPD  = 8'b00001000,
		ST_SEL_MUL = 8'b00010000,
		ST_WALK    = 8'b00100000,
		ST_DIV     = 8'b01000000,
		ST_FIN     = 8'b10000000
	} state_t;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  entry_count_q;
	logic [SUM_W-1:0]  rs_q;
	logic              m_tvalid_q;
	logic [OUT_DW-1:0] m_tdata_q;

	op_t               op_q;
	logic [IDX_W-1:0]  idx_q;
	logic [SB-1:0]     val_q;
	logic [FRAC_W-1:0] frac_q;
	logic [SUM_W-1:0]  thr_q;
	logic [PW-1:0]     psum_q;
	logic [SB-1:0]     mx_q, mn_q;
	logic [AW-1:0]     res_sel_q;
	logic [PW-1:0]     res_avg_q;

	logic [AW-1:0]     rd_ptr_q;
	logic              issued_all_q;
	logic              rd_vld_s1;
	logic [AW-1:0]     rd_idx_s1;

	logic              accept;
	logic              out_free;
	logic [CW+CNT_W-1:0] ec_ext;
	logic [CW-1:0]     act_n, act_m1;
	logic [AW-1:0]     last_idx;
	logic [AW+IDX_W-1:0] idx_ext;
	logic [AW-1:0]     wr_addr;
	logic              idx_ok;
	logic [VAL_W+SB-1:0] val_ext;

	logic              clearing;
	logic              tbl_upd;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [SB-1:0]     mem_wdata;
	logic [AW-1:0]     raddr;
	logic [SB-1:0]     rdata;

	logic [SUM_W+SB-1:0] rs_upd;
	logic [PROD_W-1:0] prod, prod_rnd;
	logic [PW-1:0]     acc;
	logic [CMPW-1:0]   acc_cmp, thr_cmp, sum_ext;
	logic              hit, walk_fire, walk_last, sel_end, stat_end, issue, first;
	logic [SB-1:0]     mx_nxt, mn_nxt;

	logic              div_start;
	logic [PW-1:0]     quotient;
	div_stat_t         div_stat;

	logic [AW+IDX_W-1:0] sel_ext;
	logic [SB+OUT_W-1:0] mx_ext, mn_ext;
	logic [PW+OUT_W-1:0] avg_ext;

	// entries in use: zero counts as one, large values saturate
	always_comb begin
		ec_ext = {{CW{1'b0}}, entry_count_q};
		if (entry_count_q == '0) begin
			act_n = CW'(1);
		end else if (32'(entry_count_q) > MAX_ENTRIES) begin
			act_n = CW'(MAX_ENTRIES);
		end else begin
			act_n = ec_ext[CW-1:0];
		end
		act_m1   = act_n - CW'(1);
		last_idx = act_m1[AW-1:0];
	end

	// write address and range check, strength kept to SB bits
	always_comb begin
		idx_ext = {{AW{1'b0}}, idx_q};
		wr_addr = idx_ext[AW-1:0];
		idx_ok  = 32'(idx_q) < MAX_ENTRIES;
		val_ext = {{SB{1'b0}}, s_tdata[IDX_W +: VAL_W]};
	end

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid_q || m_tready;

	// running total correction on a write: minus old, plus new, modulo 2^40
	assign rs_upd = {{SB{1'b0}}, rs_q} - {{SUM_W{1'b0}}, rdata} + {{SUM_W{1'b0}}, val_q};

	// select threshold: ceil(fraction * total / 2^16)
	assign prod     = PROD_W'(frac_q) * PROD_W'(rs_q);
	assign prod_rnd = prod + ROUND_UP;

	// walk over the table, one RAM word per cycle
	always_comb begin
		issue     = (state_q == ST_WALK) && !issued_all_q;
		raddr     = (state_q == ST_WR_RD) ? wr_addr : rd_ptr_q;
		acc       = psum_q + PW'(rdata);
		acc_cmp   = {{SUM_W{1'b0}}, acc};
		thr_cmp   = {{PW{1'b0}}, thr_q};
		sum_ext   = {{SUM_W{1'b0}}, acc};
		hit       = acc_cmp >= thr_cmp;
		walk_fire = (state_q == ST_WALK) && rd_vld_s1;
		walk_last = (rd_idx_s1 == last_idx);
		sel_end   = walk_fire && (op_q == OP_SELECT) && (hit || walk_last);
		stat_end  = walk_fire && (op_q == OP_STATS) && walk_last;
		first     = (rd_idx_s1 == '0);
		mx_nxt    = (first || rdata > mx_q) ? rdata : mx_q;
		mn_nxt    = (first || rdata < mn_q) ? rdata : mn_q;
		div_start = stat_end;
		clearing  = (state_q == ST_CLR);
		tbl_upd   = (state_q == ST_WR_UPD) && idx_ok;
		mem_we    = tbl_upd || clearing;
		mem_waddr = clearing ? rd_ptr_q : wr_addr;
		mem_wdata = clearing ? '0 : val_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLR: begin
				if (rd_ptr_q == AW'(MAX_ENTRIES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					unique case (op_t'(s_tuser))
						OP_WRITE:  state_d = ST_WR_RD;
						OP_SELECT: state_d = ST_SEL_MUL;
						OP_STATS:  state_d = ST_WALK;
						OP_NOP:    state_d = ST_FIN;
					endcase
				end
			end
			ST_WR_RD:   state_d = ST_WR_UPD;
			ST_WR_UPD:  state_d = ST_FIN;
			ST_SEL_MUL: state_d = ST_WALK;
			ST_WALK: begin
				if (sel_end) begin
					state_d = ST_FIN;
				end else if (stat_end) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLR;
			entry_count_q <= CNT_W'(1);
			rs_q          <= '0;
			m_tvalid_q    <= 1'b0;
			rd_ptr_q      <= '0;
			issued_all_q  <= 1'b0;
			rd_vld_s1     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wen) begin
				entry_count_q <= cfg_wdata;
			end
			if (tbl_upd) begin
				rs_q <= rs_upd[SUM_W-1:0];
			end else if (stat_end) begin
				rs_q <= sum_ext[SUM_W-1:0];
			end
			if (state_q == ST_FIN && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			// pointer walks the table for the clearing pass and for reads
			if (accept) begin
				rd_ptr_q     <= '0;
				issued_all_q <= 1'b0;
			end else if (issue || clearing) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
				if (issue && rd_ptr_q == last_idx) begin
					issued_all_q <= 1'b1;
				end
			end
			rd_vld_s1 <= issue;
		end
	end

	// result field formatting
	always_comb begin
		sel_ext = {{IDX_W{1'b0}}, res_sel_q};
		mx_ext  = {{OUT_W{1'b0}}, mx_q};
		mn_ext  = {{OUT_W{1'b0}}, mn_q};
		avg_ext = {{OUT_W{1'b0}}, res_avg_q};
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= op_t'(s_tuser);
			idx_q     <= s_tdata[IDX_W-1:0];
			val_q     <= val_ext[SB-1:0];
			frac_q    <= s_tdata[IDX_W+VAL_W +: FRAC_W];
			psum_q    <= '0;
			mx_q      <= '0;
			mn_q      <= '0;
			res_sel_q <= '0;
			res_avg_q <= '0;
		end
		if (state_q == ST_SEL_MUL) begin
			thr_q <= prod_rnd[PROD_W-1:FRAC_W];
		end
		rd_idx_s1 <= rd_ptr_q;
		if (walk_fire) begin
			psum_q <= acc;
		end
		if (walk_fire && op_q == OP_STATS) begin
			mx_q <= mx_nxt;
			mn_q <= mn_nxt;
		end
		if (sel_end) begin
			res_sel_q <= rd_idx_s1;
		end
		if (div_stat.done) begin
			res_avg_q <= quotient;
		end
		if (state_q == ST_FIN && out_free) begin
			m_tdata_q <= {avg_ext[OUT_W-1:0], rs_q, mn_ext[OUT_W-1:0], mx_ext[OUT_W-1:0],
				sel_ext[IDX_W-1:0]};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// strength table
	rws_ram #(
		.WIDTH (SB),
		.DEPTH (MAX_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// average: statistics sum over entries in use
	rws_div #(
		.DW (PW),
		.VW (CW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (acc),
		.divisor  (act_n),
		.quotient (quotient),
		.stat     (div_stat)
	);

`ifndef ASSERT_OFF
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide state");

	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		walk_fire |-> (rd_idx_s1 <= last_idx))
		else $error("table walk read past the last entry in use");

	a_sel_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && op_q == OP_SELECT) |-> (res_sel_q <= last_idx))
		else $error("selected index beyond entries in use");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("second word taken while one is in progress");
`endif

endmodule
